FILE: src/tctl_pkg.sv
// ---------------------------------------------------------------------------
// tctl_pkg
// Shared types and constants for the thermostat heater and fan controller.
// ---------------------------------------------------------------------------
package tctl_pkg;

  // Input item opcodes (the remaining code is a plain status poll)
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_COMMAND = 2'd1,
    OP_BUTTON  = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_NEAR  = 2'd0,
    STAT_BELOW = 2'd1,
    STAT_ABOVE = 2'd2
  } stat_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FILTER_ALPHA  = 3'd0,
    CFG_DUTY_MAX      = 3'd1,
    CFG_FAN_ON_ERROR  = 3'd2,
    CFG_FAN_OFF_ERROR = 3'd3,
    CFG_BUTTON_STEP   = 3'd4,
    CFG_SP_FLOOR      = 3'd5,
    CFG_SP_CEILING    = 3'd6,
    CFG_LOCKOUT_MS    = 3'd7
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic [15:0]        ALPHA_RST    = 16'd6554;
  localparam logic [9:0]         DUTY_MAX_RST = 10'd1000;
  localparam logic signed [12:0] FAN_ON_RST   = -13'sd128;
  localparam logic signed [12:0] FAN_OFF_RST  = -13'sd26;
  localparam logic [11:0]        STEP_RST     = 12'd128;
  localparam logic [14:0]        FLOOR_RST    = 15'd3840;
  localparam logic [14:0]        CEIL_RST     = 15'd15360;
  localparam logic [15:0]        LOCKOUT_RST  = 16'd200;

  // Error is setpoint (15b unsigned) minus average (16b signed)
  localparam int ERR_W = 18;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] sensor_temp;
    logic signed [15:0] command_value;
    logic               up_pressed;
    logic               down_pressed;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         heater_duty;
    logic               fan_on;
    logic               heat_led;
    logic               cool_led;
    logic signed [15:0] filtered_temp;
    logic [14:0]        setpoint;
    logic [1:0]         status;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;      // latch the accepted item
    logic filt_mul;  // filter product
    logic avg_upd;   // write the moving average
    logic err_upd;   // register setpoint minus average
    logic fan_upd;   // duty product
    logic duty_upd;  // write heater duty and fan hysteresis
    logic setp_cmd;  // apply setpoint command
    logic lock_chk;  // evaluate button lockout
    logic btn_up;    // apply up button
    logic btn_dn;    // apply down button
    logic out_load;  // load the result register
  } dp_cmd_t;

endpackage

FILE: src/tctl_datapath.sv
// ---------------------------------------------------------------------------
// tctl_datapath
// Configuration registers, thermostat state, filter and duty arithmetic,
// and the result register.
// ---------------------------------------------------------------------------
module tctl_datapath import tctl_pkg::*; #(
  parameter int TEMP_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  dp_cmd_t               cmd,
  output out_item_t             out_data
);

  localparam int PROD2_W = TEMP_FRAC_BITS + 11;
  localparam logic signed [ERR_W-1:0] ERR_TWO   = ERR_W'(2 << TEMP_FRAC_BITS);
  localparam logic signed [ERR_W-1:0] ERR_HALF  = ERR_W'(1 << (TEMP_FRAC_BITS - 1));
  localparam logic signed [20:0]      CMD_TOP   = 21'(100 << TEMP_FRAC_BITS);
  localparam logic [14:0]             TARGET_RST = 15'(25 << TEMP_FRAC_BITS);

  // configuration
  logic [15:0]        alpha_r;
  logic [9:0]         duty_max_r;
  logic signed [12:0] fan_on_r;
  logic signed [12:0] fan_off_r;
  logic [11:0]        step_r;
  logic [14:0]        floor_r;
  logic [14:0]        ceil_r;
  logic [15:0]        lockout_r;

  // thermostat state
  logic signed [15:0] avg_r;
  logic [14:0]        target_r;
  logic               fan_r;
  logic [9:0]         duty_r;
  logic [31:0]        last_r;

  // working registers
  in_item_t               item_r;
  logic signed [33:0]     prod1_r;
  logic signed [ERR_W-1:0] err_r;
  logic [PROD2_W-1:0]     prod2_r;
  logic                   lock_ok_r;
  out_item_t              out_r;

  logic signed [16:0]      diff;
  logic signed [33:0]      prod1_nxt;
  logic signed [33:0]      prod_rnd;
  logic signed [15:0]      avg_filt;
  logic signed [ERR_W-1:0] err_nxt;
  logic                    err_pos;
  logic signed [ERR_W-1:0] fan_on_x;
  logic signed [ERR_W-1:0] fan_off_x;
  logic [PROD2_W-1:0]      prod2_nxt;
  logic signed [20:0]      cmd_x;
  logic                    cmd_ok;
  logic [31:0]             since_press;
  logic [15:0]             up_sum;
  logic signed [16:0]      dn_diff;
  logic signed [ERR_W-1:0] avg_x;
  logic signed [ERR_W-1:0] tgt_x;
  stat_t                   stat;

  always_comb begin
    diff      = $signed({item_r.sensor_temp[15], item_r.sensor_temp})
              - $signed({avg_r[15], avg_r});
    prod1_nxt = $signed({{17{diff[16]}}, diff}) * $signed({18'd0, alpha_r});
    // round to nearest, ties up, then keep the 16-bit increment
    prod_rnd  = prod1_r + 34'sd32768;
    avg_filt  = avg_r + $signed(prod_rnd[31:16]);

    err_nxt   = $signed({3'd0, target_r}) - $signed({{2{avg_r[15]}}, avg_r});
    err_pos   = !err_r[ERR_W-1] && (err_r != '0);
    fan_on_x  = $signed({{(ERR_W-13){fan_on_r[12]}}, fan_on_r});
    fan_off_x = $signed({{(ERR_W-13){fan_off_r[12]}}, fan_off_r});
    prod2_nxt = PROD2_W'(err_r[TEMP_FRAC_BITS:0]) * PROD2_W'(duty_max_r);

    cmd_x  = $signed({{5{item_r.command_value[15]}}, item_r.command_value});
    cmd_ok = (cmd_x > 21'sd0) && (cmd_x < CMD_TOP);

    since_press = item_r.now_ms - last_r;
    up_sum      = {1'b0, target_r} + {4'd0, step_r};
    dn_diff     = $signed({2'd0, target_r}) - $signed({5'd0, step_r});

    avg_x = $signed({{2{avg_r[15]}}, avg_r});
    tgt_x = $signed({3'd0, target_r});
    priority if (avg_x < tgt_x) begin
      stat = STAT_BELOW;
    end else if (avg_x > tgt_x + ERR_HALF) begin
      stat = STAT_ABOVE;
    end else begin
      stat = STAT_NEAR;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= ALPHA_RST;
      duty_max_r <= DUTY_MAX_RST;
      fan_on_r   <= FAN_ON_RST;
      fan_off_r  <= FAN_OFF_RST;
      step_r     <= STEP_RST;
      floor_r    <= FLOOR_RST;
      ceil_r     <= CEIL_RST;
      lockout_r  <= LOCKOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FILTER_ALPHA:  alpha_r    <= cfg_data;
        CFG_DUTY_MAX:      duty_max_r <= cfg_data[9:0];
        CFG_FAN_ON_ERROR:  fan_on_r   <= $signed(cfg_data[12:0]);
        CFG_FAN_OFF_ERROR: fan_off_r  <= $signed(cfg_data[12:0]);
        CFG_BUTTON_STEP:   step_r     <= cfg_data[11:0];
        CFG_SP_FLOOR:      floor_r    <= cfg_data[14:0];
        CFG_SP_CEILING:    ceil_r     <= cfg_data[14:0];
        CFG_LOCKOUT_MS:    lockout_r  <= cfg_data;
        default:           alpha_r    <= alpha_r;
      endcase
    end
  end

  // thermostat state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r    <= '0;
      target_r <= TARGET_RST;
      fan_r    <= 1'b0;
      duty_r   <= '0;
      last_r   <= '0;
    end else begin
      if (cmd.avg_upd) begin
        avg_r <= (avg_r == '0) ? item_r.sensor_temp : avg_filt;
      end
      // fan and duty change on the same edge so they never overlap
      if (cmd.duty_upd) begin
        priority if (err_pos) begin
          fan_r <= 1'b0;
        end else if (err_r < fan_on_x) begin
          fan_r <= 1'b1;
        end else if (err_r > fan_off_x) begin
          fan_r <= 1'b0;
        end else begin
          fan_r <= fan_r;
        end
      end
      if (cmd.duty_upd) begin
        priority if (!err_pos) begin
          duty_r <= '0;
        end else if (err_r >= ERR_TWO) begin
          duty_r <= duty_max_r;
        end else begin
          duty_r <= prod2_r[TEMP_FRAC_BITS+10:TEMP_FRAC_BITS+1];
        end
      end
      if (cmd.setp_cmd && cmd_ok) begin
        target_r <= item_r.command_value[14:0];
      end
      if (cmd.btn_up && lock_ok_r && item_r.up_pressed) begin
        target_r <= (up_sum > {1'b0, ceil_r}) ? ceil_r : up_sum[14:0];
        last_r   <= item_r.now_ms;
      end
      if (cmd.btn_dn && lock_ok_r && item_r.down_pressed) begin
        target_r <= (dn_diff < $signed({2'd0, floor_r})) ? floor_r : dn_diff[14:0];
        last_r   <= item_r.now_ms;
      end
    end
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    if (cmd.take)     item_r    <= in_data;
    if (cmd.filt_mul) prod1_r   <= prod1_nxt;
    if (cmd.err_upd)  err_r     <= err_nxt;
    if (cmd.fan_upd)  prod2_r   <= prod2_nxt;
    if (cmd.lock_chk) lock_ok_r <= since_press >= {16'd0, lockout_r};
    if (cmd.out_load) begin
      out_r.heater_duty   <= duty_r;
      out_r.fan_on        <= fan_r;
      out_r.heat_led      <= duty_r != '0;
      out_r.cool_led      <= (duty_r == '0) && fan_r;
      out_r.filtered_temp <= avg_r;
      out_r.setpoint      <= target_r;
      out_r.status        <= stat;
    end
  end

  assign out_data = out_r;

  // heater and fan never run together
  a_heat_excl_fan: assert property (@(posedge clk) disable iff (!rst_n)
    (duty_r != '0) |-> !fan_r)
    else $error("heater duty and fan both active");

endmodule

FILE: src/tctl_ctrl.sv
// ---------------------------------------------------------------------------
// tctl_ctrl
// Sequencer: walks each item through the datapath steps and owns the
// valid flag of the result register.
// ---------------------------------------------------------------------------
module tctl_ctrl import tctl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_FILT  = 11'b000_0000_0010,
    S_AVG   = 11'b000_0000_0100,
    S_ERR   = 11'b000_0000_1000,
    S_DUTY  = 11'b000_0001_0000,
    S_APPLY = 11'b000_0010_0000,
    S_CMD   = 11'b000_0100_0000,
    S_LOCK  = 11'b000_1000_0000,
    S_UP    = 11'b001_0000_0000,
    S_DN    = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (in_opcode)
            OP_SAMPLE:  state_nxt = S_FILT;
            OP_COMMAND: state_nxt = S_CMD;
            OP_BUTTON:  state_nxt = S_LOCK;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_FILT: begin
        cmd.filt_mul = 1'b1;
        state_nxt    = S_AVG;
      end
      S_AVG: begin
        cmd.avg_upd = 1'b1;
        state_nxt   = S_ERR;
      end
      S_ERR: begin
        cmd.err_upd = 1'b1;
        state_nxt   = S_DUTY;
      end
      S_DUTY: begin
        cmd.fan_upd = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        cmd.duty_upd = 1'b1;
        state_nxt    = S_DONE;
      end
      S_CMD: begin
        cmd.setp_cmd = 1'b1;
        state_nxt    = S_DONE;
      end
      S_LOCK: begin
        cmd.lock_chk = 1'b1;
        state_nxt    = S_UP;
      end
      S_UP: begin
        cmd.btn_up = 1'b1;
        state_nxt  = S_DN;
      end
      S_DN: begin
        cmd.btn_dn = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before item finished");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !cmd.out_load) |=> !out_valid_r)
    else $error("result presented twice");

endmodule

FILE: src/thermostat_heater_fan_controller.sv
// ---------------------------------------------------------------------------
// thermostat_heater_fan_controller
// Thermostat with moving-average filter, proportional heater duty and fan
// hysteresis, plus setpoint commands and button stepping with lockout.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  -------------------------------
//  in       input      in_valid / in_stall  in_item_t (opcode, temp, cmd,
//                                           buttons, now_ms)
//  out      output     out_valid/out_stall  out_item_t (duty, fan, leds,
//                                           average, setpoint, status)
//  cfg      input      cfg_wr_en            cfg_index, cfg_data (16 bits)
//
//  Steps of each taken item: a sample runs filter multiply, average write,
//  error, duty multiply, duty write and result load; a setpoint command
//  applies the value and loads; a button poll checks the lockout, applies
//  up, then down, and loads; the unused opcode only loads the result. The
//  sequencer steps one shared datapath, so the sample, with its two dependent
//  multiplies, takes longest. Reset is synchronous; no clearing pass.
//  A stalled result waits in the output register while the next item is
//  taken and worked; only its final load waits for the transfer.
// ---------------------------------------------------------------------------
module thermostat_heater_fan_controller import tctl_pkg::*; #(
  parameter int TEMP_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_wr_en,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  dp_cmd_t cmd;

  // Sequencer: one item at a time, the result register decouples the
  // output side so a waiting transfer does not hold up the next item.
  tctl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: configuration, thermostat state and the arithmetic steps.
  tctl_datapath #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the thermostat heater and fan controller: a short
// table of directed items, then register settings from extreme to random,
// each followed by bursts of random samples, setpoint commands and button
// polls. Each result is compared field by field with its table row or model.
// ---------------------------------------------------------------------------
module tb;
  import tctl_pkg::*;

  localparam int TEMP_FRAC   = 8;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int SETTLE      = 20;
  localparam int LIMIT       = 400000;
  localparam int MAX_PRINTS  = 30;

  // The fourth opcode has no package name; it only reports the state.
  localparam logic [1:0] OP_STATUS_POLL = 2'd3;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } vec_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  cfg_idx_t              cfg_index = CFG_FILTER_ALPHA;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  thermostat_heater_fan_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies, mirrored on every write.
  int k_alpha    = 6554;
  int k_duty_max = 1000;
  int k_fan_on   = -128;
  int k_fan_off  = -26;
  int k_step     = 128;
  int k_floor    = 3840;
  int k_ceil     = 15360;
  int k_lockout  = 200;

  // Thermostat state as the bench sees it.
  int          est_avg     = 0;
  int          est_sp      = 25 << TEMP_FRAC;
  bit          est_fan     = 1'b0;
  int          est_duty    = 0;
  bit [31:0]   est_last_ms = '0;

  out_item_t   expected_readings[$];
  bit [31:0]   clock_ms = 32'd1000;

  int cycles, n_mismatch, n_checked, n_settings;
  int n_samples, n_commands, n_refused, n_buttons, n_locked, n_polls;
  int n_saturated, n_fan_samples;

  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;

  // -------------------------------------------------------------------------
  // Model of one item: update the state, return the reading it produces.
  // -------------------------------------------------------------------------
  function automatic out_item_t advance_thermostat(input in_item_t it);
    longint    acc;
    int        err, t, v;
    bit [31:0] gap_ms;
    out_item_t r;
    case (it.opcode)
      OP_SAMPLE: begin
        n_samples++;
        // An empty average takes the sample as is; else blend and round.
        if (est_avg == 0) begin
          est_avg = int'($signed(it.sensor_temp));
        end else begin
          acc = longint'($signed(it.sensor_temp)) * longint'(k_alpha)
              + longint'(est_avg) * longint'(65536 - k_alpha) + 64'sd32768;
          est_avg = int'(acc >>> 16);
        end
        err = est_sp - est_avg;
        if (err > 0) begin
          est_fan = 1'b0;
          if (err >= (2 << TEMP_FRAC)) begin
            est_duty = k_duty_max;
            n_saturated++;
          end else begin
            est_duty = int'((longint'(err) * longint'(k_duty_max)) >>> (TEMP_FRAC + 1));
          end
        end else begin
          // Hysteresis band: between the two thresholds the fan holds.
          est_duty = 0;
          if (err < k_fan_on) est_fan = 1'b1;
          else if (err > k_fan_off) est_fan = 1'b0;
        end
        if (est_fan) n_fan_samples++;
      end
      OP_COMMAND: begin
        n_commands++;
        v = int'($signed(it.command_value));
        if (v > 0 && v < (100 << TEMP_FRAC)) est_sp = v;
        else n_refused++;
      end
      OP_BUTTON: begin
        n_buttons++;
        gap_ms = it.now_ms - est_last_ms;
        if (gap_ms < k_lockout) begin
          n_locked++;
        end else begin
          // Up applies first, then down; each clamps on its own side.
          if (it.up_pressed) begin
            t = est_sp + k_step;
            if (t > k_ceil) t = k_ceil;
            est_sp = t;
            est_last_ms = it.now_ms;
          end
          if (it.down_pressed) begin
            t = est_sp - k_step;
            if (t < k_floor) t = k_floor;
            est_sp = t;
            est_last_ms = it.now_ms;
          end
        end
      end
      default: n_polls++;
    endcase
    r.heater_duty   = est_duty[9:0];
    r.fan_on        = est_fan;
    r.heat_led      = (est_duty > 0);
    r.cool_led      = (est_duty == 0) && est_fan;
    r.filtered_temp = est_avg[15:0];
    r.setpoint      = est_sp[14:0];
    if (est_avg < est_sp) r.status = STAT_BELOW;
    else if (est_avg > est_sp + (1 << (TEMP_FRAC - 1))) r.status = STAT_ABOVE;
    else r.status = STAT_NEAR;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Item builders. Fields the opcode does not use carry random noise.
  // -------------------------------------------------------------------------
  function automatic in_item_t noise_item();
    in_item_t it;
    it.opcode        = OP_STATUS_POLL;
    it.sensor_temp   = 16'($urandom);
    it.command_value = 16'($urandom);
    it.up_pressed    = 1'($urandom_range(1));
    it.down_pressed  = 1'($urandom_range(1));
    it.now_ms        = $urandom;
    return it;
  endfunction

  function automatic in_item_t mk_sample(input int raw);
    in_item_t it;
    it = noise_item();
    it.opcode      = OP_SAMPLE;
    it.sensor_temp = raw[15:0];
    return it;
  endfunction

  function automatic in_item_t mk_cmd(input int v);
    in_item_t it;
    it = noise_item();
    it.opcode        = OP_COMMAND;
    it.command_value = v[15:0];
    return it;
  endfunction

  function automatic in_item_t mk_btn(input bit up, input bit dn, input bit [31:0] now);
    in_item_t it;
    it = noise_item();
    it.opcode       = OP_BUTTON;
    it.up_pressed   = up;
    it.down_pressed = dn;
    it.now_ms       = now;
    return it;
  endfunction

  function automatic out_item_t mk_reading(input int duty, input bit fan, input bit heat,
                                           input bit cool, input int avg, input int sp,
                                           input stat_t st);
    out_item_t r;
    r.heater_duty   = duty[9:0];
    r.fan_on        = fan;
    r.heat_led      = heat;
    r.cool_led      = cool;
    r.filtered_temp = avg[15:0];
    r.setpoint      = sp[14:0];
    r.status        = st;
    return r;
  endfunction

  // Random item: mostly samples around the setpoint, so the error sweeps the
  // proportional band and both fan thresholds; the rest commands and polls.
  function automatic in_item_t draw_item();
    int pick, raw, v;
    pick = $urandom_range(99);
    if (pick < 45) begin
      v = $urandom_range(19);
      if (v == 0) raw = int'($urandom_range(4)) - 2;
      else if (v < 4) raw = int'($signed(16'($urandom)));
      else raw = est_sp + int'($urandom_range(3840)) - 1024;
      return mk_sample(raw);
    end else if (pick < 65) begin
      v = $urandom_range(19);
      if (v < 3) return mk_cmd(int'($signed(16'($urandom))));
      if (v < 5) return mk_cmd(est_sp + int'($urandom_range(1200)) - 600);
      return mk_cmd($urandom_range(1, 25599));
    end else if (pick < 93) begin
      if ($urandom_range(9) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(0, 2 * k_lockout + 10);
      return mk_btn(1'($urandom_range(1)), 1'($urandom_range(1)), clock_ms);
    end
    return noise_item();
  endfunction

  // -------------------------------------------------------------------------
  // Driving and checking
  // -------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (n_mismatch < MAX_PRINTS)
      $display("[%0d] %s: got %0d, want %0d", cycles, what, got, want);
    n_mismatch++;
  endtask

  // Hold valid until the transfer, then queue what the item should produce.
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t guess;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = advance_thermostat(it);
    expected_readings.push_back(typed ? want : guess);
  endtask

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_settings(input int vals[8]);
    cfg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_t'(i);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i][15:0];
      case (idx)
        CFG_FILTER_ALPHA:  k_alpha    = vals[i] & 32'hFFFF;
        CFG_DUTY_MAX:      k_duty_max = vals[i] & 32'h3FF;
        CFG_FAN_ON_ERROR:  k_fan_on   = int'($signed(vals[i][12:0]));
        CFG_FAN_OFF_ERROR: k_fan_off  = int'($signed(vals[i][12:0]));
        CFG_BUTTON_STEP:   k_step     = vals[i] & 32'hFFF;
        CFG_SP_FLOOR:      k_floor    = vals[i] & 32'h7FFF;
        CFG_SP_CEILING:    k_ceil     = vals[i] & 32'h7FFF;
        CFG_LOCKOUT_MS:    k_lockout  = vals[i] & 32'hFFFF;
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  task automatic compare_reading(input out_item_t got);
    out_item_t exp;
    if (expected_readings.size() == 0) begin
      flag_mismatch("result with nothing pending", got.filtered_temp, 0);
    end else begin
      exp = expected_readings.pop_front();
      n_checked++;
      if (got.heater_duty !== exp.heater_duty)
        flag_mismatch("heater_duty", got.heater_duty, exp.heater_duty);
      if (got.fan_on !== exp.fan_on) flag_mismatch("fan_on", got.fan_on, exp.fan_on);
      if (got.heat_led !== exp.heat_led)
        flag_mismatch("heat_led", got.heat_led, exp.heat_led);
      if (got.cool_led !== exp.cool_led)
        flag_mismatch("cool_led", got.cool_led, exp.cool_led);
      if (got.filtered_temp !== exp.filtered_temp)
        flag_mismatch("filtered_temp", $signed(got.filtered_temp), $signed(exp.filtered_temp));
      if (got.setpoint !== exp.setpoint)
        flag_mismatch("setpoint", got.setpoint, exp.setpoint);
      if (got.status !== exp.status) flag_mismatch("status", got.status, exp.status);
    end
  endtask

  // Sample the result channel at the edge, before any update of this step.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) compare_reading(out_data);
  end

  // Receiver: switch between free-running, light, heavy and periodic stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(9) < 7);
      default:  out_stall <= ((cycles % 5) < 2);
    endcase
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles,
               expected_readings.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    vec_t directed[];
    int   vals[8];
    int   sent, burst;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset state, refused and accepted commands, the load
    // of an empty average, heater saturation, fan turn-on, button lockout at
    // and below its boundary, both buttons, timestamp wrap, ceiling clamp and
    // temperature extremes.
    directed = '{
      '{noise_item(), 1'b1, mk_reading(0, 0, 0, 0, 0, 6400, STAT_BELOW)},
      '{mk_btn(1, 0, 0), 1'b1, mk_reading(0, 0, 0, 0, 0, 6400, STAT_BELOW)},
      '{mk_sample(6400), 1'b1, mk_reading(0, 0, 0, 0, 6400, 6400, STAT_NEAR)},
      '{mk_cmd(0), 1'b1, mk_reading(0, 0, 0, 0, 6400, 6400, STAT_NEAR)},
      '{mk_cmd(25600), 1'b1, mk_reading(0, 0, 0, 0, 6400, 6400, STAT_NEAR)},
      '{mk_cmd(-32768), 1'b1, mk_reading(0, 0, 0, 0, 6400, 6400, STAT_NEAR)},
      '{mk_cmd(25599), 1'b1, mk_reading(0, 0, 0, 0, 6400, 25599, STAT_BELOW)},
      '{mk_sample(6400), 1'b1, mk_reading(1000, 0, 1, 0, 6400, 25599, STAT_BELOW)},
      '{mk_cmd(1), 1'b1, mk_reading(1000, 0, 1, 0, 6400, 1, STAT_ABOVE)},
      '{mk_sample(6400), 1'b1, mk_reading(0, 1, 0, 1, 6400, 1, STAT_ABOVE)},
      '{mk_cmd(32767), 1'b1, mk_reading(0, 1, 0, 1, 6400, 1, STAT_ABOVE)},
      '{mk_btn(0, 1, 100), 1'b1, mk_reading(0, 1, 0, 1, 6400, 1, STAT_ABOVE)},
      '{mk_cmd(6500), 1'b0, '0},
      '{mk_sample(6400), 1'b0, '0},
      '{mk_cmd(6300), 1'b0, '0},
      '{mk_sample(6400), 1'b0, '0},
      '{mk_btn(1, 0, 200), 1'b0, '0},
      '{mk_btn(0, 1, 399), 1'b0, '0},
      '{mk_btn(1, 1, 400), 1'b0, '0},
      '{mk_btn(0, 1, 32'hFFFF_FFFF), 1'b0, '0},
      '{mk_btn(1, 0, 150), 1'b0, '0},
      '{mk_cmd(15300), 1'b0, '0},
      '{mk_btn(1, 0, 1000), 1'b0, '0},
      '{mk_sample(32767), 1'b0, '0},
      '{mk_sample(-32768), 1'b0, '0}
    };

    foreach (directed[i]) begin
      offer_item(directed[i].item, directed[i].typed, directed[i].want);
      if ($urandom_range(2) == 0) idle_sender($urandom_range(1, 4));
    end

    // Random phases: reset settings, both extremes, then random settings.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        if (ph == 1) begin
          vals[CFG_FILTER_ALPHA]  = 65535;
          vals[CFG_DUTY_MAX]      = 1023;
          vals[CFG_FAN_ON_ERROR]  = -2560;
          vals[CFG_FAN_OFF_ERROR] = 0;
          vals[CFG_BUTTON_STEP]   = 2560;
          vals[CFG_SP_FLOOR]      = 0;
          vals[CFG_SP_CEILING]    = 25599;
          vals[CFG_LOCKOUT_MS]    = 65535;
        end else if (ph == 2) begin
          // Floor above ceiling and thresholds swapped.
          vals[CFG_FILTER_ALPHA]  = 0;
          vals[CFG_DUTY_MAX]      = 0;
          vals[CFG_FAN_ON_ERROR]  = 0;
          vals[CFG_FAN_OFF_ERROR] = -2560;
          vals[CFG_BUTTON_STEP]   = 0;
          vals[CFG_SP_FLOOR]      = 25599;
          vals[CFG_SP_CEILING]    = 0;
          vals[CFG_LOCKOUT_MS]    = 0;
        end else begin
          vals[CFG_FILTER_ALPHA]  = $urandom_range(65535);
          vals[CFG_DUTY_MAX]      = $urandom_range(1023);
          vals[CFG_FAN_ON_ERROR]  = -int'($urandom_range(2560));
          vals[CFG_FAN_OFF_ERROR] = -int'($urandom_range(2560));
          vals[CFG_BUTTON_STEP]   = $urandom_range(2560);
          vals[CFG_SP_FLOOR]      = $urandom_range(25599);
          vals[CFG_SP_CEILING]    = $urandom_range(25599);
          vals[CFG_LOCKOUT_MS]    = $urandom_range(400);
        end
        load_settings(vals);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 32);
        for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
          offer_item(draw_item(), 1'b0, '0);
          sent++;
        end
        // Some bursts run straight into the next one with no gap.
        if ($urandom_range(3) != 0) idle_sender($urandom_range(1, 12));
      end
    end

    drain();
    $display("Covered %0d samples, %0d setpoint commands (%0d refused), %0d button polls"
             , n_samples, n_commands, n_refused, n_buttons);
    $display("(%0d locked out), %0d status polls over %0d settings; %0d results checked"
             , n_locked, n_polls, n_settings + 1, n_checked);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
